FILE: sv/kmi_pkg.sv
package kmi_pkg;

	localparam int ANG_W  = 17;
	localparam int TIME_W = 24;
	localparam int LEN_W  = 16;
	localparam int POS_W  = 16;

	localparam logic [TIME_W-1:0] TIME_MAX = 24'hFF_FFFF;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_APPEND = 2'd0;
	localparam cmd_t CMD_LOCATE = 2'd1;
	localparam cmd_t CMD_QUERY  = 2'd2;
	localparam cmd_t CMD_NONE   = 2'd3;

	typedef logic [2:0] status_t;
	localparam status_t STS_OK        = 3'd0;
	localparam status_t STS_NO_MOVES  = 3'd1;
	localparam status_t STS_BEFORE    = 3'd2;
	localparam status_t STS_PAST_END  = 3'd3;
	localparam status_t STS_FULL      = 3'd4;
	localparam status_t STS_NO_LOCATE = 3'd5;

	typedef struct packed {
		logic signed [ANG_W-1:0] angle;
		logic [TIME_W-1:0]       end_t;
		logic [LEN_W-1:0]        len;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] z;
		logic signed [POS_W-1:0] y;
	} move_word_t;

	localparam int MOVE_W = $bits(move_word_t);

	typedef struct packed {
		logic                    start;
		logic signed [ANG_W-1:0] b;
		logic signed [ANG_W-1:0] e;
		logic [LEN_W-1:0]        dt;
		logic [LEN_W-1:0]        span;
	} lerp_req_t;

endpackage

FILE: sv/kmi_ram.sv
module kmi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/kmi_lerp.sv
module kmi_lerp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  kmi_pkg::lerp_req_t                     req,
	output logic                                   done,
	output logic signed [kmi_pkg::ANG_W-1:0]       res
);

	localparam int DIFF_W = kmi_pkg::ANG_W + 1;
	localparam int PROD_W = DIFF_W + kmi_pkg::LEN_W + 1;
	localparam int MAG_W  = PROD_W - 1;
	localparam int DVD_W  = MAG_W + 2;
	localparam int DIV_W  = kmi_pkg::LEN_W + 1;
	localparam int CNT_W  = $clog2(DVD_W + 1);
	localparam int Q_W    = DIFF_W + 1;

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_MUL  = 2'd1;
	localparam logic [1:0] L_DIV  = 2'd2;
	localparam logic [1:0] L_FIN  = 2'd3;

	logic [1:0]                        lst_q;
	logic signed [kmi_pkg::ANG_W-1:0]  b_q;
	logic signed [DIFF_W-1:0]          diff_q;
	logic [kmi_pkg::LEN_W-1:0]         dt_q;
	logic [kmi_pkg::LEN_W-1:0]         span_q;
	logic                              neg_q;
	logic [DVD_W-1:0]                  dvd_q;
	logic [DIV_W-1:0]                  rem_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              done_q;
	logic signed [kmi_pkg::ANG_W-1:0]  res_q;

	logic signed [PROD_W-1:0] prod_w;
	logic [PROD_W-1:0]        abs_w;
	logic [DIV_W:0]           rem_n;
	logic [DIV_W-1:0]         div_w;
	logic                     qbit_w;
	logic [Q_W:0]             qpos_w;
	logic signed [Q_W:0]      qsig_w;
	logic signed [Q_W:0]      sum_w;

	always_comb begin
		prod_w = PROD_W'(diff_q) * $signed({1'b0, dt_q});
		abs_w  = prod_w[PROD_W-1] ? PROD_W'(-prod_w) : PROD_W'(prod_w);
		div_w  = {span_q, 1'b0};
		rem_n  = {rem_q, dvd_q[DVD_W-1]};
		qbit_w = rem_n >= {1'b0, div_w};
		qpos_w = {1'b0, dvd_q[Q_W-1:0]};
		qsig_w = neg_q ? -$signed(qpos_w) : $signed(qpos_w);
		sum_w  = (Q_W+1)'(b_q) + qsig_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lst_q  <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (lst_q == L_FIN);
			case (lst_q)
				L_IDLE: begin
					if (req.start) begin
						lst_q <= (req.span == '0) ? L_FIN : L_MUL;
					end
				end
				L_MUL: lst_q <= L_DIV;
				L_DIV: begin
					if (cnt_q == CNT_W'(1)) begin
						lst_q <= L_FIN;
					end
				end
				L_FIN: lst_q <= L_IDLE;
				default: lst_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (lst_q)
			L_IDLE: begin
				b_q    <= req.b;
				diff_q <= DIFF_W'(req.e) - DIFF_W'(req.b);
				dt_q   <= req.dt;
				span_q <= req.span;
				neg_q  <= 1'b0;
				dvd_q  <= '0;
			end
			L_MUL: begin
				neg_q <= diff_q[DIFF_W-1];
				dvd_q <= {abs_w[MAG_W-1:0], 1'b0} + DVD_W'(span_q);
				rem_q <= '0;
				cnt_q <= CNT_W'(DVD_W);
			end
			L_DIV: begin
				rem_q <= qbit_w ? DIV_W'(rem_n - {1'b0, div_w}) : DIV_W'(rem_n);
				dvd_q <= {dvd_q[DVD_W-2:0], qbit_w};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			L_FIN: res_q <= kmi_pkg::ANG_W'(sum_w);
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: sv/keyframe_move_interpolator.sv
// channel | signals                                        | flow
// in      | in_valid, in_stall, command .. query_time      | one command per beat
// out     | out_valid, out_stall, status .. script_length  | one result per command 0..2
//
// query: reads each move it needs from the move memory (cached move, search steps,
// previous move), then runs 4 interpolations on the shared bit-serial divider
// a beat is taken only in the idle state; command 3 is taken and dropped
// arst_n clears the per-servo valid bits and the script length; no memory sweep
// a result waits in the output register under out_stall while the next beat is taken
module keyframe_move_interpolator #(
	parameter int SERVOS          = 32,
	parameter int MOVES_PER_SERVO = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            command,
	input  logic [4:0]                            servo,
	input  logic signed [16:0]                    end_angle,
	input  logic [15:0]                           duration,
	input  logic signed [15:0]                    loc_x,
	input  logic signed [15:0]                    loc_z,
	input  logic signed [15:0]                    loc_y,
	input  logic [23:0]                           query_time,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [2:0]                            status,
	output logic signed [16:0]                    angle,
	output logic signed [15:0]                    pos_x,
	output logic signed [15:0]                    pos_z,
	output logic signed [15:0]                    pos_y,
	output logic [7:0]                            move_index,
	output logic [23:0]                           script_length
);

	localparam int SW    = (SERVOS > 1) ? $clog2(SERVOS) : 1;
	localparam int MW    = $clog2(MOVES_PER_SERVO);
	localparam int HW    = $clog2(MOVES_PER_SERVO + 1);
	localparam int DEPTH = SERVOS * MOVES_PER_SERVO;
	localparam int AW    = $clog2(DEPTH);
	localparam int SRV_W = HW + MW + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SWAIT = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_MWAIT = 4'd3;
	localparam logic [3:0] S_MDATA = 4'd4;
	localparam logic [3:0] S_AWR   = 4'd5;
	localparam logic [3:0] S_LGO   = 4'd6;
	localparam logic [3:0] S_LWAIT = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	localparam logic [2:0] PH_APREV = 3'd0;
	localparam logic [2:0] PH_LOC   = 3'd1;
	localparam logic [2:0] PH_CACHE = 3'd2;
	localparam logic [2:0] PH_SRCH  = 3'd3;
	localparam logic [2:0] PH_PREV  = 3'd4;

	logic [3:0]                 st_q;
	logic [2:0]                 ph_q;
	logic [1:0]                 k_q;
	logic [SERVOS-1:0]          svalid_q;
	logic [23:0]                longest_q;

	kmi_pkg::cmd_t              cmd_q;
	logic [4:0]                 servo_q;
	logic signed [16:0]         angle_q;
	logic [15:0]                dur_q;
	logic signed [15:0]         lx_q, lz_q, ly_q;
	logic [23:0]                t_q;
	logic [HW-1:0]              held_q;
	logic [MW-1:0]              cur_q;
	logic                       curv_q;
	logic [MW-1:0]              i_q;
	logic [AW-1:0]              maddr_q;
	logic [23:0]                beg_q;
	logic [15:0]                dt_q;
	kmi_pkg::move_word_t        cw_q, pw_q;

	kmi_pkg::status_t           wst_q;
	logic signed [16:0]         wang_q;
	logic signed [15:0]         wx_q, wz_q, wy_q;
	logic [MW-1:0]              widx_q;

	logic                       ovalid_q;
	kmi_pkg::status_t           ost_q;
	logic signed [16:0]         oang_q;
	logic signed [15:0]         ox_q, oz_q, oy_q;
	logic [7:0]                 oidx_q;
	logic [23:0]                olen_q;

	logic [SW-1:0]              sidx;
	logic                       ok_servo;
	logic [AW-1:0]              base_w;
	logic [SRV_W-1:0]           srd, swdata;
	logic                       swe;
	logic [HW-1:0]              held_w;
	logic [MW-1:0]              cur_w;
	logic                       curv_w;
	kmi_pkg::move_word_t        mrd, mwdata;
	logic                       mwe;
	logic [AW-1:0]              mwaddr;
	logic [23:0]                mbeg_w;
	logic                       inside_w;
	logic [24:0]                sum_w;
	logic [23:0]                end_w;
	logic                       in_acc;
	kmi_pkg::lerp_req_t         lreq;
	logic                       ldone;
	logic signed [16:0]         lres;

	always_comb begin
		sidx     = SW'(servo_q);
		ok_servo = 32'(servo_q) < SERVOS;
		base_w   = AW'(AW'(sidx) * AW'(MOVES_PER_SERVO));
		held_w   = svalid_q[sidx] ? srd[SRV_W-1 -: HW] : '0;
		cur_w    = srd[MW:1];
		curv_w   = svalid_q[sidx] & srd[0];
		mbeg_w   = mrd.end_t - 24'(mrd.len);
		inside_w = !(t_q < mbeg_w) && !(t_q > mrd.end_t);
		sum_w    = {1'b0, beg_q} + 25'(dur_q);
		end_w    = sum_w[24] ? kmi_pkg::TIME_MAX : sum_w[23:0];
		in_acc   = in_valid && !in_stall;
	end

	// write-back: new move on append, new end location on locate; servo entry on append and on a search hit
	always_comb begin
		mwe    = (st_q == S_AWR) || (st_q == S_MDATA && ph_q == PH_LOC);
		mwaddr = (st_q == S_AWR) ? base_w + AW'(held_q) : maddr_q;
		mwdata = mrd;
		if (st_q == S_AWR) begin
			mwdata.angle = angle_q;
			mwdata.end_t = end_w;
			mwdata.len   = 16'(end_w - beg_q);
			mwdata.x     = '0;
			mwdata.z     = '0;
			mwdata.y     = '0;
		end else begin
			mwdata.x = lx_q;
			mwdata.z = lz_q;
			mwdata.y = ly_q;
		end
		swe    = (st_q == S_AWR) ||
			(st_q == S_MDATA && ph_q == PH_SRCH && !(mbeg_w > t_q) && !(mrd.end_t < t_q));
		swdata = (st_q == S_AWR) ? {held_q + HW'(1), cur_q, curv_q} : {held_q, i_q, 1'b1};
	end

	always_comb begin
		lreq.start = (st_q == S_LGO);
		lreq.dt    = dt_q;
		lreq.span  = cw_q.len;
		case (k_q)
			2'd0: begin
				lreq.b = pw_q.angle;
				lreq.e = cw_q.angle;
			end
			2'd1: begin
				lreq.b = 17'(pw_q.x);
				lreq.e = 17'(cw_q.x);
			end
			2'd2: begin
				lreq.b = 17'(pw_q.z);
				lreq.e = 17'(cw_q.z);
			end
			default: begin
				lreq.b = 17'(pw_q.y);
				lreq.e = 17'(cw_q.y);
			end
		endcase
	end

	kmi_ram #(.WIDTH(SRV_W), .DEPTH(SERVOS)) u_srv_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (sidx),
		.wdata (swdata),
		.raddr (sidx),
		.rdata (srd)
	);

	kmi_ram #(.WIDTH(kmi_pkg::MOVE_W), .DEPTH(DEPTH)) u_move_ram (
		.clk   (clk),
		.we    (mwe),
		.waddr (mwaddr),
		.wdata (mwdata),
		.raddr (maddr_q),
		.rdata (mrd)
	);

	kmi_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lreq),
		.done   (ldone),
		.res    (lres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			ph_q      <= PH_APREV;
			k_q       <= '0;
			svalid_q  <= '0;
			longest_q <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (st_q == S_OUT && (!ovalid_q || !out_stall)) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_acc && command != kmi_pkg::CMD_NONE) begin
						st_q <= S_SWAIT;
					end
				end
				S_SWAIT: st_q <= S_DISP;
				S_DISP: begin
					case (cmd_q)
						kmi_pkg::CMD_APPEND: begin
							if (!ok_servo || held_w >= HW'(MOVES_PER_SERVO)) begin
								st_q <= S_OUT;
							end else if (held_w == '0) begin
								st_q <= S_AWR;
							end else begin
								ph_q <= PH_APREV;
								st_q <= S_MWAIT;
							end
						end
						kmi_pkg::CMD_LOCATE: begin
							ph_q <= PH_LOC;
							st_q <= (!ok_servo || held_w == '0) ? S_OUT : S_MWAIT;
						end
						default: begin
							ph_q <= (curv_w && HW'(cur_w) < held_w) ? PH_CACHE : PH_SRCH;
							st_q <= (!ok_servo || held_w == '0) ? S_OUT : S_MWAIT;
						end
					endcase
				end
				S_MWAIT: st_q <= S_MDATA;
				S_MDATA: begin
					case (ph_q)
						PH_APREV: st_q <= S_AWR;
						PH_LOC:   st_q <= S_OUT;
						PH_CACHE: begin
							if (!inside_w) begin
								ph_q <= PH_SRCH;
								st_q <= S_MWAIT;
							end else if (cur_q == '0) begin
								st_q <= S_LGO;
							end else begin
								ph_q <= PH_PREV;
								st_q <= S_MWAIT;
							end
						end
						PH_SRCH: begin
							if (mbeg_w > t_q) begin
								st_q <= S_OUT;
							end else if (mrd.end_t < t_q) begin
								st_q <= (HW'(i_q) + HW'(1) == held_q) ? S_OUT : S_MWAIT;
							end else if (i_q == '0) begin
								st_q <= S_LGO;
							end else begin
								ph_q <= PH_PREV;
								st_q <= S_MWAIT;
							end
						end
						default: st_q <= S_LGO;
					endcase
				end
				S_AWR: begin
					svalid_q[sidx] <= 1'b1;
					if (end_w > longest_q) begin
						longest_q <= end_w;
					end
					st_q <= S_OUT;
				end
				S_LGO: st_q <= S_LWAIT;
				S_LWAIT: begin
					if (ldone) begin
						k_q  <= k_q + 2'd1;
						st_q <= (k_q == 2'd3) ? S_OUT : S_LGO;
					end
				end
				S_OUT: begin
					if (!ovalid_q || !out_stall) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				cmd_q   <= command;
				servo_q <= servo;
				angle_q <= end_angle;
				dur_q   <= duration;
				lx_q    <= loc_x;
				lz_q    <= loc_z;
				ly_q    <= loc_y;
				t_q     <= query_time;
				wst_q   <= kmi_pkg::STS_OK;
				wang_q  <= '0;
				wx_q    <= '0;
				wz_q    <= '0;
				wy_q    <= '0;
				widx_q  <= '0;
			end
			S_DISP: begin
				held_q <= held_w;
				cur_q  <= cur_w;
				curv_q <= curv_w;
				beg_q  <= '0;
				case (cmd_q)
					kmi_pkg::CMD_APPEND: begin
						maddr_q <= base_w + AW'(held_w) - AW'(1);
						if (!ok_servo || held_w >= HW'(MOVES_PER_SERVO)) begin
							wst_q <= kmi_pkg::STS_FULL;
						end
					end
					kmi_pkg::CMD_LOCATE: begin
						maddr_q <= base_w + AW'(held_w) - AW'(1);
						if (!ok_servo || held_w == '0) begin
							wst_q <= kmi_pkg::STS_NO_LOCATE;
						end
					end
					default: begin
						if (!ok_servo || held_w == '0) begin
							wst_q <= kmi_pkg::STS_NO_MOVES;
						end
						if (curv_w && HW'(cur_w) < held_w) begin
							maddr_q <= base_w + AW'(cur_w);
							i_q     <= cur_w;
						end else begin
							maddr_q <= base_w;
							i_q     <= '0;
						end
					end
				endcase
			end
			S_MDATA: begin
				case (ph_q)
					PH_APREV: beg_q <= mrd.end_t;
					PH_LOC:   widx_q <= MW'(held_q - HW'(1));
					PH_CACHE: begin
						cw_q <= mrd;
						pw_q <= mrd;
						dt_q <= 16'(t_q - mbeg_w);
						if (!inside_w) begin
							maddr_q <= base_w;
							i_q     <= '0;
						end else begin
							maddr_q <= maddr_q - AW'(1);
						end
					end
					PH_SRCH: begin
						cw_q    <= mrd;
						pw_q    <= mrd;
						dt_q    <= 16'(t_q - mbeg_w);
						maddr_q <= (mrd.end_t < t_q) ? maddr_q + AW'(1) : maddr_q - AW'(1);
						if (mbeg_w > t_q) begin
							wst_q <= kmi_pkg::STS_BEFORE;
						end else if (mrd.end_t < t_q) begin
							i_q <= i_q + MW'(1);
							if (HW'(i_q) + HW'(1) == held_q) begin
								wst_q <= kmi_pkg::STS_PAST_END;
							end
						end
					end
					default: pw_q <= mrd;
				endcase
			end
			S_AWR: widx_q <= MW'(held_q);
			S_LWAIT: begin
				if (ldone) begin
					widx_q <= i_q;
					case (k_q)
						2'd0: wang_q <= lres;
						2'd1: wx_q <= 16'(lres);
						2'd2: wz_q <= 16'(lres);
						default: wy_q <= 16'(lres);
					endcase
				end
			end
			S_OUT: begin
				if (!ovalid_q || !out_stall) begin
					ost_q  <= wst_q;
					oang_q <= wang_q;
					ox_q   <= wx_q;
					oz_q   <= wz_q;
					oy_q   <= wy_q;
					oidx_q <= 8'(widx_q);
					olen_q <= longest_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall      = (st_q != S_IDLE);
	assign out_valid     = ovalid_q;
	assign status        = ost_q;
	assign angle         = oang_q;
	assign pos_x         = ox_q;
	assign pos_z         = oz_q;
	assign pos_y         = oy_q;
	assign move_index    = oidx_q;
	assign script_length = olen_q;

endmodule

FILE: sv/kmi_chk.sv
module kmi_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         status,
	input logic signed [16:0] angle,
	input logic signed [15:0] pos_x,
	input logic signed [15:0] pos_z,
	input logic signed [15:0] pos_y,
	input logic [7:0]         move_index,
	input logic [23:0]        script_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(angle) &&
			$stable(move_index) && $stable(script_length))
		else $error("result beat changed under stall");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= kmi_pkg::STS_NO_LOCATE)
		else $error("status code out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != kmi_pkg::STS_OK |->
			angle == '0 && pos_x == '0 && pos_z == '0 && pos_y == '0 && move_index == '0)
		else $error("failed command carries a non-zero payload");

endmodule

bind keyframe_move_interpolator kmi_chk u_kmi_chk (.*);

FILE: dv/tb_keyframe_move_interpolator.sv
module tb_keyframe_move_interpolator;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_SERVO = 32;
	localparam int N_MOVE  = 256;

	typedef struct {
		kmi_pkg::cmd_t           cmd;
		logic [4:0]              servo;
		logic signed [16:0]      ang;
		logic [15:0]             dur;
		logic signed [15:0]      x;
		logic signed [15:0]      z;
		logic signed [15:0]      y;
		logic [23:0]             t;
	} cmd_beat_t;

	typedef struct {
		kmi_pkg::status_t        status;
		logic signed [16:0]      angle;
		logic signed [15:0]      pos_x;
		logic signed [15:0]      pos_z;
		logic signed [15:0]      pos_y;
		logic [7:0]              move_index;
		logic [23:0]             script_length;
	} move_result_t;

	class move_table_sb;
		int          end_ang [N_SERVO*N_MOVE];
		int unsigned end_tm  [N_SERVO*N_MOVE];
		int unsigned span_ms [N_SERVO*N_MOVE];
		int          mx [N_SERVO*N_MOVE];
		int          mz [N_SERVO*N_MOVE];
		int          my [N_SERVO*N_MOVE];
		int unsigned held [N_SERVO];
		int unsigned cur [N_SERVO];
		bit          cur_ok [N_SERVO];
		int unsigned longest;
		move_result_t due_q [$];
		int          errors;

		function new();
			foreach (held[i]) begin
				held[i] = 0;
				cur[i] = 0;
				cur_ok[i] = 0;
			end
			longest = 0;
			errors = 0;
		endfunction

		function int lerp(int b, int e, int unsigned dt, int unsigned span);
			longint num, mag, q;
			if (span == 0)
				return b;
			num = longint'(e - b) * longint'(dt);
			mag = num < 0 ? -num : num;
			q = (mag * 2 + longint'(span)) / (2 * longint'(span));
			if (num < 0)
				q = -q;
			return int'(longint'(b) + q);
		endfunction

		function int unsigned begin_of(int unsigned slot);
			return end_tm[slot] - span_ms[slot];
		endfunction

		function kmi_pkg::status_t find_move(int unsigned s, int unsigned t);
			int unsigned base;
			base = s * N_MOVE;
			for (int unsigned i = 0; i < held[s]; i++) begin
				if (begin_of(base + i) > t)
					return kmi_pkg::STS_BEFORE;
				if (end_tm[base + i] < t)
					continue;
				cur[s] = i;
				cur_ok[s] = 1;
				return kmi_pkg::STS_OK;
			end
			return kmi_pkg::STS_PAST_END;
		endfunction

		function void note(cmd_beat_t b);
			move_result_t r;
			int unsigned s, n, slot, bg, en, i, dt;
			int abeg;
			if (b.cmd == kmi_pkg::CMD_NONE)
				return;
			s = b.servo;
			r = '{kmi_pkg::STS_OK, '0, '0, '0, '0, '0, '0};
			if (b.cmd == kmi_pkg::CMD_APPEND) begin
				if (held[s] >= N_MOVE) begin
					r.status = kmi_pkg::STS_FULL;
				end else begin
					n = held[s];
					slot = s * N_MOVE + n;
					bg = n == 0 ? 0 : end_tm[slot - 1];
					en = bg + b.dur;
					if (en > kmi_pkg::TIME_MAX)
						en = kmi_pkg::TIME_MAX;
					end_ang[slot] = b.ang;
					end_tm[slot] = en;
					span_ms[slot] = en - bg;
					mx[slot] = 0;
					mz[slot] = 0;
					my[slot] = 0;
					held[s] = n + 1;
					if (en > longest)
						longest = en;
					r.move_index = n[7:0];
				end
			end else if (b.cmd == kmi_pkg::CMD_LOCATE) begin
				if (held[s] == 0) begin
					r.status = kmi_pkg::STS_NO_LOCATE;
				end else begin
					slot = s * N_MOVE + held[s] - 1;
					mx[slot] = b.x;
					mz[slot] = b.z;
					my[slot] = b.y;
					r.move_index = 8'(held[s] - 1);
				end
			end else begin
				if (held[s] == 0) begin
					r.status = kmi_pkg::STS_NO_MOVES;
				end else begin
					if (!cur_ok[s] || cur[s] >= held[s])
						r.status = find_move(s, b.t);
					if (r.status == kmi_pkg::STS_OK) begin
						slot = s * N_MOVE + cur[s];
						if (b.t < begin_of(slot) || b.t > end_tm[slot])
							r.status = find_move(s, b.t);
					end
					if (r.status == kmi_pkg::STS_OK) begin
						i = cur[s];
						slot = s * N_MOVE + i;
						dt = b.t - begin_of(slot);
						abeg = i == 0 ? end_ang[slot] : end_ang[slot - 1];
						r.angle = 17'(lerp(abeg, end_ang[slot], dt, span_ms[slot]));
						if (i == 0) begin
							r.pos_x = 16'(mx[slot]);
							r.pos_z = 16'(mz[slot]);
							r.pos_y = 16'(my[slot]);
						end else begin
							r.pos_x = 16'(lerp(mx[slot - 1], mx[slot], dt, span_ms[slot]));
							r.pos_z = 16'(lerp(mz[slot - 1], mz[slot], dt, span_ms[slot]));
							r.pos_y = 16'(lerp(my[slot - 1], my[slot], dt, span_ms[slot]));
						end
						r.move_index = i[7:0];
					end
				end
			end
			r.script_length = longest[23:0];
			due_q.push_back(r);
		endfunction

		function void check(move_result_t got);
			move_result_t w;
			if (due_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			w = due_q.pop_front();
			if (got.status !== w.status) begin
				$error("status exp %0d got %0d", w.status, got.status);
				errors++;
			end
			if (got.angle !== w.angle) begin
				$error("angle exp %0d got %0d", w.angle, got.angle);
				errors++;
			end
			if (got.pos_x !== w.pos_x) begin
				$error("pos_x exp %0d got %0d", w.pos_x, got.pos_x);
				errors++;
			end
			if (got.pos_z !== w.pos_z) begin
				$error("pos_z exp %0d got %0d", w.pos_z, got.pos_z);
				errors++;
			end
			if (got.pos_y !== w.pos_y) begin
				$error("pos_y exp %0d got %0d", w.pos_y, got.pos_y);
				errors++;
			end
			if (got.move_index !== w.move_index) begin
				$error("move_index exp %0d got %0d", w.move_index, got.move_index);
				errors++;
			end
			if (got.script_length !== w.script_length) begin
				$error("script_length exp %0d got %0d", w.script_length, got.script_length);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         command;
	logic [4:0]         servo;
	logic signed [16:0] end_angle;
	logic [15:0]        duration;
	logic signed [15:0] loc_x;
	logic signed [15:0] loc_z;
	logic signed [15:0] loc_y;
	logic [23:0]        query_time;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic signed [16:0] angle;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_z;
	logic signed [15:0] pos_y;
	logic [7:0]         move_index;
	logic [23:0]        script_length;

	move_table_sb sb = new();
	int send_idle = 0;
	int recv_idle = 0;
	int results_seen = 0;

	keyframe_move_interpolator #(
		.SERVOS(N_SERVO),
		.MOVES_PER_SERVO(N_MOVE)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .servo(servo), .end_angle(end_angle), .duration(duration),
		.loc_x(loc_x), .loc_z(loc_z), .loc_y(loc_y), .query_time(query_time),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .angle(angle), .pos_x(pos_x), .pos_z(pos_z), .pos_y(pos_y),
		.move_index(move_index), .script_length(script_length)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_keyframe_move_interpolator: FAIL");
		$finish;
	end

	task automatic send_beat(cmd_beat_t b);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		command    <= b.cmd;
		servo      <= b.servo;
		end_angle  <= b.ang;
		duration   <= b.dur;
		loc_x      <= b.x;
		loc_z      <= b.z;
		loc_y      <= b.y;
		query_time <= b.t;
		in_valid   <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note(b);
	endtask

	function automatic cmd_beat_t noise_beat(kmi_pkg::cmd_t c, int s);
		cmd_beat_t b;
		b.cmd   = c;
		b.servo = 5'(s);
		b.ang   = 17'(int'($urandom_range(0, 72000)) - 36000);
		case ($urandom_range(0, 3))
			0: b.dur = 16'd0;
			1: b.dur = 16'($urandom_range(1, 300));
			2: b.dur = 16'hFFFF;
			default: b.dur = 16'($urandom);
		endcase
		b.x = 16'($urandom);
		b.z = 16'($urandom);
		b.y = 16'($urandom);
		b.t = 24'($urandom);
		return b;
	endfunction

	function automatic cmd_beat_t pick_beat();
		cmd_beat_t b;
		int s, r, n, k;
		int unsigned last;
		s = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 7);
		r = $urandom_range(0, 99);
		b = noise_beat(r < 40 ? kmi_pkg::CMD_APPEND : r < 55 ? kmi_pkg::CMD_LOCATE :
			r < 95 ? kmi_pkg::CMD_QUERY : kmi_pkg::CMD_NONE, s);
		n = sb.held[s];
		if (b.cmd == kmi_pkg::CMD_QUERY && n > 0 && $urandom_range(0, 9) != 0) begin
			last = sb.end_tm[s * N_MOVE + n - 1];
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, n - 1);
				b.t = 24'(sb.end_tm[s * N_MOVE + k] + $urandom_range(0, 1));
			end else begin
				b.t = 24'($urandom_range(0, last + 3));
			end
		end
		return b;
	endfunction

	task automatic run_directed();
		cmd_beat_t b;
		b = noise_beat(kmi_pkg::CMD_QUERY, 0);
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_LOCATE, 0);
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_APPEND, 0); b.ang = 17'sd36000; b.dur = 16'd0;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 0); b.t = 24'd0;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_LOCATE, 0); b.x = 16'sh7FFF; b.z = -16'sh8000; b.y = 16'sd0;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_APPEND, 0); b.ang = -17'sd36000; b.dur = 16'hFFFF;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_LOCATE, 0); b.x = -16'sh8000; b.z = 16'sh7FFF; b.y = -16'sd1;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 0); b.t = 24'd32767;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 0); b.t = 24'd32768;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 0); b.t = 24'd65535;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 0); b.t = 24'd65536;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_APPEND, 0); b.ang = 17'sd0; b.dur = 16'd0;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 0); b.t = 24'd65535;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 0); b.t = kmi_pkg::TIME_MAX;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_NONE, 0);
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 0); b.t = 24'd0;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_APPEND, 31); b.dur = 16'd1;
		send_beat(b);
		b = noise_beat(kmi_pkg::CMD_QUERY, 31); b.t = 24'd1;
		send_beat(b);
	endtask

	initial begin
		cmd_beat_t b;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = kmi_pkg::CMD_NONE;
		servo = '0;
		end_angle = '0;
		duration = '0;
		loc_x = '0;
		loc_z = '0;
		loc_y = '0;
		query_time = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 33;
		recv_idle = 52;
		run_directed();
		for (int i = 0; i < 370; i++)
			send_beat(pick_beat());

		// pause until drained
		in_valid <= 1'b0;
		while (sb.due_q.size() != 0)
			@(posedge clk);
		@(posedge clk);

		send_idle = 52;
		recv_idle = 33;
		for (int i = 0; i < 370; i++)
			send_beat(pick_beat());

		send_idle = 0;
		recv_idle = 0;
		// fill one table past its end
		for (int i = 0; i < N_MOVE + 2; i++) begin
			b = noise_beat(kmi_pkg::CMD_APPEND, 20);
			b.dur = 16'($urandom_range(0, 400));
			send_beat(b);
			if ($urandom_range(0, 7) == 0)
				send_beat(noise_beat(kmi_pkg::CMD_LOCATE, 20));
		end
		for (int i = 0; i < 20; i++) begin
			b = noise_beat(kmi_pkg::CMD_QUERY, 20);
			b.t = 24'($urandom_range(0, sb.end_tm[20 * N_MOVE + N_MOVE - 1] + 2));
			send_beat(b);
		end
		for (int i = 0; i < 120; i++)
			send_beat(pick_beat());

		in_valid <= 1'b0;
		while (sb.due_q.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		if (sb.errors == 0 && sb.due_q.size() == 0)
			$display("tb_keyframe_move_interpolator: PASS");
		else
			$display("tb_keyframe_move_interpolator: FAIL");
		$finish;
	end

	initial begin
		move_result_t got;
		int hold;
		hold = 0;
		out_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = '{status, angle, pos_x, pos_z, pos_y, move_index, script_length};
				sb.check(got);
				results_seen++;
				if (results_seen == 100)
					hold = 3000;
			end
			// long hold-off to back the block up
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(0, 99) < recv_idle;
			end
		end
	end

endmodule

FILE: sim.f
sv/kmi_pkg.sv
sv/kmi_ram.sv
sv/kmi_lerp.sv
sv/keyframe_move_interpolator.sv
sv/kmi_chk.sv
dv/tb_keyframe_move_interpolator.sv
